// File: rtl/kmf_pkg.sv
// ----------------------------------------------------------------------------
// kmf_pkg
// Shared types, constants and helpers for the k-mer minimizer finder.
// ----------------------------------------------------------------------------
package kmf_pkg;

  localparam int unsigned MaxKmerChars = 255;
  localparam int unsigned CountW       = 9;
  localparam int unsigned OffsetW      = 8;
  localparam int unsigned WindowW      = 64;
  localparam int unsigned MLenW        = 6;
  localparam int unsigned MaxMLen      = 32;
  localparam logic [MLenW-1:0] MLenReset = 6'd8;

  localparam logic [7:0] CharC = 8'h43;
  localparam logic [7:0] CharT = 8'h54;
  localparam logic [7:0] CharG = 8'h47;

  localparam logic [1:0] CodeOther = 2'd0;
  localparam logic [1:0] CodeC     = 2'd1;
  localparam logic [1:0] CodeT     = 2'd2;
  localparam logic [1:0] CodeG     = 2'd3;

  typedef struct packed {
    logic [7:0] base_char;
    logic       end_of_kmer;
  } in_item_t;

  typedef struct packed {
    logic [WindowW-1:0] minimizer_value;
    logic [OffsetW-1:0] minimizer_position;
    logic               length_overflow;
  } out_item_t;

  typedef struct packed {
    logic [WindowW-1:0] window;
    logic [WindowW-1:0] best_value;
    logic [OffsetW-1:0] best_offset;
    logic [CountW-1:0]  chars_seen;
    logic               best_valid;
  } kmf_state_t;

  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [1:0] code;
    case (ch)
      CharC:   code = CodeC;
      CharT:   code = CodeT;
      CharG:   code = CodeG;
      default: code = CodeOther;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/kmf_step.sv
// ----------------------------------------------------------------------------
// kmf_step
// One-character update: shift in the base code, mask to m bases, compare
// against the kept minimizer, and form the result on the last character.
// ----------------------------------------------------------------------------
module kmf_step (
  input  kmf_pkg::kmf_state_t            state_i,
  input  kmf_pkg::in_item_t              item_i,
  input  logic [kmf_pkg::MLenW-1:0]      mlen_i,
  output kmf_pkg::kmf_state_t            state_o,
  output kmf_pkg::out_item_t             result_o
);

  logic [kmf_pkg::MLenW-1:0]   m_eff;
  logic [kmf_pkg::MLenW-1:0]   shamt;
  logic [kmf_pkg::WindowW-1:0] mask;
  logic [kmf_pkg::WindowW-1:0] win_new;
  logic [kmf_pkg::CountW-1:0]  n;
  logic [kmf_pkg::CountW-1:0]  offs;
  kmf_pkg::kmf_state_t         upd;

  always_comb begin
    if (mlen_i == '0) begin
      m_eff = kmf_pkg::MLenW'(1);
    end else if (mlen_i > kmf_pkg::MLenW'(kmf_pkg::MaxMLen)) begin
      m_eff = kmf_pkg::MLenW'(kmf_pkg::MaxMLen);
    end else begin
      m_eff = mlen_i;
    end
  end

  // two bits per base; m = 32 fills the whole word
  assign shamt = {m_eff[kmf_pkg::MLenW-2:0], 1'b0};
  assign mask  = (m_eff == kmf_pkg::MLenW'(kmf_pkg::MaxMLen)) ? '1
                                                              : ~({kmf_pkg::WindowW{1'b1}} << shamt);

  assign n       = state_i.chars_seen + kmf_pkg::CountW'(1);
  assign win_new = {state_i.window[kmf_pkg::WindowW-3:0], kmf_pkg::base_code(item_i.base_char)}
                   & mask;
  assign offs    = n - kmf_pkg::CountW'(m_eff);

  always_comb begin
    upd = state_i;
    if (state_i.chars_seen < kmf_pkg::CountW'(kmf_pkg::MaxKmerChars)) begin
      upd.chars_seen = n;
      upd.window     = win_new;
      if (n >= kmf_pkg::CountW'(m_eff)) begin
        // strict less-than keeps the earliest offset on ties
        if (!state_i.best_valid || (win_new < state_i.best_value)) begin
          upd.best_value  = win_new;
          upd.best_offset = offs[kmf_pkg::OffsetW-1:0];
          upd.best_valid  = 1'b1;
        end
      end
    end else begin
      upd.chars_seen = kmf_pkg::CountW'(kmf_pkg::MaxKmerChars + 1);
    end
  end

  always_comb begin
    if (upd.best_valid) begin
      result_o.minimizer_value    = upd.best_value;
      result_o.minimizer_position = upd.best_offset;
    end else begin
      // short k-mer: partial packed value at position zero
      result_o.minimizer_value    = upd.window;
      result_o.minimizer_position = '0;
    end
    result_o.length_overflow = (upd.chars_seen > kmf_pkg::CountW'(kmf_pkg::MaxKmerChars));
  end

  assign state_o = item_i.end_of_kmer ? '0 : upd;

endmodule

// File: rtl/kmer_minimizer_finder_top.sv
// Result path: after the input transfer of the last character, the input register feeds the
// result register, which loads the result once it holds no untaken result.
// Throughput: one character per cycle; a last character waits only while the result
// register holds an untaken result.
// Reset clears window, minimizer, count and the valid flags; minimizer_length resets to 8.
// ----------------------------------------------------------------------------
// kmer_minimizer_finder_top
// Streams k-mer characters and reports the lexicographic 2-bit minimizer.
// ----------------------------------------------------------------------------
module kmer_minimizer_finder_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  kmf_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output kmf_pkg::out_item_t         out_item_o,
  input  logic                       cfg_we_i,
  input  logic [kmf_pkg::MLenW-1:0]  cfg_data_i
);

  logic [kmf_pkg::MLenW-1:0] mlen_q;
  logic                      s1_valid_q, s1_valid_d;
  kmf_pkg::in_item_t         s1_item_q;
  kmf_pkg::kmf_state_t       state_q, state_d;
  kmf_pkg::out_item_t        result;
  logic                      out_valid_q, out_valid_d;
  kmf_pkg::out_item_t        out_item_q;
  logic                      out_free, s1_adv, in_xfer, out_load;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_item_q.end_of_kmer || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_load   = s1_valid_q && s1_item_q.end_of_kmer && out_free;

  kmf_step u_step (
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .mlen_i   (mlen_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_comb begin
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mlen_q      <= kmf_pkg::MLenReset;
      s1_valid_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mlen_q <= cfg_data_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item_i;
    end
    if (out_load) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
